// ===== sv/slp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the signed decimal list parser.
// Depends on nothing; used by every module of the block.
package slp_pkg;

    localparam int MAX_VALUES_DEF      = 512;
    localparam int MAX_TOKEN_CHARS_DEF = 12;
    localparam int VALUE_W             = 32;
    localparam int STATUS_W            = 3;
    localparam int STORED_COUNT_W      = 10;

    typedef logic [STATUS_W-1:0]       t_status;
    typedef logic [STORED_COUNT_W-1:0] t_stored_count;

    localparam t_status ST_OK     = 3'd0;
    localparam t_status ST_SYNTAX = 3'd1;
    localparam t_status ST_RANGE  = 3'd2;
    localparam t_status ST_DUP    = 3'd3;
    localparam t_status ST_EMPTY  = 3'd4;
    localparam t_status ST_FULL   = 3'd5;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_argument;
        logic       new_list;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        t_status                   status;
        t_stored_count             stored_count;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    scan;
        logic    emit;
        t_status code;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fin;
        logic empty;
        logic bad_syntax;
        logic bad_range;
        logic dup_hit;
        logic scan_done;
        logic full;
        logic out_free;
    } t_dp_sts;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

endpackage

// ===== sv/slp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the signed decimal list parser: request intake, token checks,
// table scan and result hand-off. Depends on slp_pkg.
module slp_ctrl
    import slp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_dp_sts i_sts,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state, n_state;
    t_status    r_code, n_code;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    if (i_sts.fin) begin
                        n_state = S_CHECK;
                    end else if (i_sts.empty) begin
                        n_code  = ST_EMPTY;
                        n_state = S_EMIT;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.bad_syntax) begin
                    n_code  = ST_SYNTAX;
                    n_state = S_EMIT;
                end else if (i_sts.bad_range) begin
                    n_code  = ST_RANGE;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.dup_hit) begin
                    n_code  = ST_DUP;
                    n_state = S_EMIT;
                end else if (i_sts.scan_done) begin
                    n_code  = i_sts.full ? ST_FULL : ST_OK;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.code = r_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== sv/slp_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the signed decimal list parser: token accumulator, value table
// with its scan port, list state and output register. Depends on slp_pkg.
module slp_dp
    import slp_pkg::*;
#(
    parameter int MAX_VALUES      = MAX_VALUES_DEF,
    parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      i_stall,
    input  t_cmd      i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int AW = $clog2(MAX_VALUES);
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int LW = $clog2(MAX_TOKEN_CHARS + 2);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TOKEN_CHARS);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VALUES);

    logic [VALUE_W-1:0] mem [MAX_VALUES];

    logic [VALUE_W-1:0] r_mag;
    logic               r_ovf, r_neg, r_dig, r_syn, r_in_tok;
    logic [LW-1:0]      r_len;
    logic               r_arg, r_err;
    logic [CW-1:0]      r_count, r_addr;
    logic               r_rdv, r_ovalid;
    logic [VALUE_W-1:0] r_q, r_val;
    t_out_item          r_out;

    // state as seen by this request, after an optional list restart
    logic [VALUE_W-1:0] e_mag;
    logic               e_ovf, e_neg, e_dig, e_syn, e_in_tok, e_arg, e_err;
    logic [LW-1:0]      e_len;
    logic [CW-1:0]      e_count;

    // state after absorbing a non-whitespace byte
    logic [VALUE_W-1:0] a_mag;
    logic               a_ovf, a_neg, a_dig, a_syn;
    logic [LW-1:0]      a_len;

    logic [7:0]         ch;
    logic               nl, eoa, sp, fin, ld_tok;
    logic [VALUE_W+3:0] prod;
    logic [VALUE_W-1:0] tok_val, limit;
    logic [CW-1:0]      count_inc;
    logic               emit_ok;

    assign ch  = i_item.character;
    assign nl  = i_item.new_list;
    assign eoa = i_item.end_of_argument;
    assign sp  = is_space(ch);

    always_comb begin
        e_mag    = nl ? '0 : r_mag;
        e_ovf    = nl ? 1'b0 : r_ovf;
        e_neg    = nl ? 1'b0 : r_neg;
        e_len    = nl ? '0 : r_len;
        e_dig    = nl ? 1'b0 : r_dig;
        e_syn    = nl ? 1'b0 : r_syn;
        e_in_tok = nl ? 1'b0 : r_in_tok;
        e_arg    = nl ? 1'b0 : r_arg;
        e_err    = nl ? 1'b0 : r_err;
        e_count  = nl ? '0 : r_count;
    end

    assign prod = {1'b0, e_mag, 3'b000} + {3'b000, e_mag, 1'b0}
                + (VALUE_W+4)'(ch - CH_ZERO);

    always_comb begin
        a_mag = e_mag;
        a_ovf = e_ovf;
        a_neg = e_neg;
        a_dig = e_dig;
        a_syn = e_syn;
        a_len = e_len;
        if (e_len >= LEN_MAX) begin
            a_syn = 1'b1;
        end else if (e_len == '0 && (ch inside {CH_MINUS, CH_PLUS})) begin
            a_neg = (ch == CH_MINUS);
        end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
            a_dig = 1'b1;
            if (prod[VALUE_W+3:VALUE_W] != '0) begin
                a_mag = '1;
                a_ovf = 1'b1;
            end else begin
                a_mag = prod[VALUE_W-1:0];
            end
        end else begin
            a_syn = 1'b1;
        end
        if (e_len <= LEN_MAX) begin
            a_len = e_len + 1'b1;
        end
    end

    assign fin    = !e_err && (sp ? e_in_tok : eoa);
    assign ld_tok = !e_err && !sp;

    assign limit     = r_neg ? NEG_LIMIT : POS_LIMIT;
    assign tok_val   = r_neg ? (VALUE_W'(0) - r_mag) : r_mag;
    assign count_inc = r_count + 1'b1;
    assign emit_ok   = (i_cmd.code == ST_OK);

    assign o_sts.fin        = fin;
    assign o_sts.empty      = !e_err && eoa && !fin && !e_arg;
    assign o_sts.bad_syntax = r_syn || !r_dig;
    assign o_sts.bad_range  = r_ovf || (r_mag > limit);
    assign o_sts.dup_hit    = r_rdv && (r_q == r_val);
    assign o_sts.scan_done  = !r_rdv && (r_addr >= r_count);
    assign o_sts.full       = (r_count >= CNT_MAX);
    assign o_sts.out_free   = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag    <= '0;
            r_ovf    <= 1'b0;
            r_neg    <= 1'b0;
            r_len    <= '0;
            r_dig    <= 1'b0;
            r_syn    <= 1'b0;
            r_in_tok <= 1'b0;
            r_arg    <= 1'b0;
            r_err    <= 1'b0;
            r_count  <= '0;
            r_addr   <= '0;
            r_rdv    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_err    <= e_err;
                r_count  <= e_count;
                r_mag    <= ld_tok ? a_mag : e_mag;
                r_ovf    <= ld_tok ? a_ovf : e_ovf;
                r_neg    <= ld_tok ? a_neg : e_neg;
                r_len    <= ld_tok ? a_len : e_len;
                r_dig    <= ld_tok ? a_dig : e_dig;
                r_syn    <= ld_tok ? a_syn : e_syn;
                r_in_tok <= ld_tok ? 1'b1 : e_in_tok;
                if (e_err) begin
                    r_arg <= e_arg;
                end else begin
                    r_arg <= eoa ? 1'b0 : (fin ? 1'b1 : e_arg);
                end
            end
            if (i_cmd.scan_start) begin
                r_addr <= '0;
                r_rdv  <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (r_addr < r_count) begin
                    r_addr <= r_addr + 1'b1;
                    r_rdv  <= 1'b1;
                end else begin
                    r_rdv <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_mag    <= '0;
                r_ovf    <= 1'b0;
                r_neg    <= 1'b0;
                r_len    <= '0;
                r_dig    <= 1'b0;
                r_syn    <= 1'b0;
                r_in_tok <= 1'b0;
                if (emit_ok) begin
                    r_count <= count_inc;
                end else begin
                    r_err <= 1'b1;
                    r_arg <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_val <= tok_val;
        end
        if (i_cmd.scan && r_addr < r_count) begin
            r_q <= mem[r_addr[AW-1:0]];
        end
        if (i_cmd.emit && emit_ok) begin
            mem[r_count[AW-1:0]] <= r_val;
        end
        if (i_cmd.emit) begin
            r_out.value        <= emit_ok ? $signed(r_val) : '0;
            r_out.status       <= i_cmd.code;
            r_out.stored_count <= t_stored_count'(emit_ok ? count_inc : r_count);
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

endmodule

// ===== sv/signed_decimal_list_parser.sv =====
`timescale 1ns / 1ps
// Top level of the signed decimal list parser: sequencer plus datapath.
// Depends on slp_pkg, slp_ctrl and slp_dp.
//
// Takes one character request per cycle while it holds no token end. A
// character that ends a token holds o_stall for the checks and, unless a
// syntax or range error stops it there, for a scan of the value table
// through its single read port; the scan ends early when a duplicate turns
// up. One that ends an empty argument holds o_stall only to emit the
// result. The stall also lasts while a still unread result holds the
// output register. Results wait in that register, so input keeps flowing
// while the sink stalls. After an error the block drops characters until a
// request with new_list.
module signed_decimal_list_parser
    import slp_pkg::*;
#(
    parameter int MAX_VALUES      = MAX_VALUES_DEF,
    parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_result
);

    t_cmd    cmd;
    t_dp_sts sts;

    slp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    slp_dp #(
        .MAX_VALUES      (MAX_VALUES),
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_stall  (i_stall),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ===== sv/slp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the signed decimal list parser, bound to the top.
// Depends on slp_pkg and signed_decimal_list_parser.
module slp_checker
    import slp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_item  i_item,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_result
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("stall asserted right after reset");

    // a restart that also ends the argument always yields a result
    a_restart_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_item.new_list && i_item.end_of_argument
        |=> o_stall)
        else $error("no work started for restart with end of argument");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status != ST_OK |-> o_result.value == 0)
        else $error("nonzero value on error result");

endmodule

bind signed_decimal_list_parser slp_checker u_slp_checker (.*);
